[hdl/bgcd_pkg.sv]
// shared constants and types for the binary gcd unit
`timescale 1ns / 1ps
package bgcd_pkg;

	// width of the operand ports and of the divisor port
	localparam int FIELD_WIDTH = 32;
	// width of the magnitudes worked on by the cell row
	localparam int DATA_WIDTH = 32;
	// shared factors of two never reach DATA_WIDTH
	localparam int TWOS_WIDTH = $clog2(DATA_WIDTH);

	// operation broadcast to every cell in a cycle
	typedef enum logic [3:0] {
		OP_HOLD,
		OP_LOAD,
		OP_HALVE_BOTH,
		OP_HALVE_A,
		OP_HALVE_B,
		OP_SUB_A,
		OP_SUB_B,
		OP_TAKE_B,
		OP_SHL_A
	} cell_op_t;

	// what one cell shows to its neighbors
	typedef struct packed {
		logic a;
		logic b;
		logic dab;
		logic dba;
	} cell_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_SCALE
	} gcd_state_t;

endpackage

[hdl/bgcd_cell.sv]
// one bit slice of the gcd operand row
`timescale 1ns / 1ps
module bgcd_cell (
	input  logic                clk,
	input  bgcd_pkg::cell_op_t  op,
	input  logic                load_a,
	input  logic                load_b,
	input  bgcd_pkg::cell_link_t link_hi,
	input  logic                lo_a,
	input  logic                borrow_ab_in,
	input  logic                borrow_ba_in,
	output bgcd_pkg::cell_link_t link_out,
	output logic                borrow_ab_out,
	output logic                borrow_ba_out
);
	import bgcd_pkg::*;

	logic a_q;
	logic b_q;
	logic a_d;
	logic b_d;

	// ripple subtract slices for a-b and b-a
	assign link_out.a = a_q;
	assign link_out.b = b_q;
	assign link_out.dab = a_q ^ b_q ^ borrow_ab_in;
	assign link_out.dba = a_q ^ b_q ^ borrow_ba_in;
	assign borrow_ab_out = (~a_q & b_q) | (~(a_q ^ b_q) & borrow_ab_in);
	assign borrow_ba_out = (~b_q & a_q) | (~(a_q ^ b_q) & borrow_ba_in);

	always_comb begin
		a_d = a_q;
		b_d = b_q;
		unique case (op)
			OP_LOAD: begin
				a_d = load_a;
				b_d = load_b;
			end
			OP_HALVE_BOTH: begin
				a_d = link_hi.a;
				b_d = link_hi.b;
			end
			OP_HALVE_A: a_d = link_hi.a;
			OP_HALVE_B: b_d = link_hi.b;
			OP_SUB_A: a_d = link_hi.dab;
			OP_SUB_B: b_d = link_hi.dba;
			OP_TAKE_B: a_d = b_q;
			OP_SHL_A: a_d = lo_a;
			default: begin
				a_d = a_q;
				b_d = b_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
	end

endmodule

[hdl/binary_gcd_unit.sv]
// binary gcd unit top level: control, cell row and result register
`timescale 1ns / 1ps
//
// channel   | direction | handshake                    | payload
// ----------+-----------+------------------------------+---------------------------------------
// operand   | in        | operand_valid / operand_stall | first_operand, second_operand
// result    | out       | result_valid / result_stall   | divisor, coprime, had_negative
//
// the magnitudes are loaded first, then the row does one halving or subtract step per cycle;
// each shared halving is counted and later undone by one left shift of the surviving value,
// after the loop has settled the surviving value in a; then the result register is written.
// the row works one pair to its end before it takes the next.
// reset clears the control state and the result valid; the cell row needs no reset.
// a new pair is taken only while the row is idle; a stall on the result side holds the
// finished gcd in the row until the result register is free, and the register lets a new
// pair enter while the previous result is still waiting
module binary_gcd_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  operand_valid,
	output logic                                  operand_stall,
	input  logic signed [bgcd_pkg::FIELD_WIDTH-1:0] first_operand,
	input  logic signed [bgcd_pkg::FIELD_WIDTH-1:0] second_operand,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic        [bgcd_pkg::FIELD_WIDTH-1:0] divisor,
	output logic                                  coprime,
	output logic                                  had_negative
);
	import bgcd_pkg::*;

	gcd_state_t state_q;
	gcd_state_t state_d;

	logic [TWOS_WIDTH-1:0] twos_q;
	logic                  neg_q;

	logic                  result_valid_q;
	logic [FIELD_WIDTH-1:0] divisor_q;
	logic                  coprime_q;
	logic                  had_negative_q;

	// raw operand bits and their magnitudes
	logic [DATA_WIDTH-1:0] raw_a;
	logic [DATA_WIDTH-1:0] raw_b;
	logic                  neg_a;
	logic                  neg_b;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;

	// cell row wiring
	cell_link_t            links [DATA_WIDTH];
	logic [DATA_WIDTH:0]   borrow_ab;
	logic [DATA_WIDTH:0]   borrow_ba;
	logic [DATA_WIDTH-1:0] a_vec;
	logic [DATA_WIDTH-1:0] b_vec;
	cell_op_t              op;

	logic operand_xfer;
	logic out_free;
	logic a_zero;
	logic b_zero;
	logic ab_equal;
	logic finished;
	logic a_greater;
	logic load_result;
	logic twos_inc;
	logic twos_dec;

	assign operand_xfer = operand_valid && !operand_stall;
	assign out_free = !result_valid_q || !result_stall;

	// magnitude of a two's complement value, most negative value included
	assign raw_a = DATA_WIDTH'(first_operand);
	assign raw_b = DATA_WIDTH'(second_operand);
	assign neg_a = raw_a[DATA_WIDTH-1];
	assign neg_b = raw_b[DATA_WIDTH-1];
	assign mag_a = neg_a ? (~raw_a + DATA_WIDTH'(1)) : raw_a;
	assign mag_b = neg_b ? (~raw_b + DATA_WIDTH'(1)) : raw_b;

	// the row: cell i holds bit i of both operands
	assign borrow_ab[0] = 1'b0;
	assign borrow_ba[0] = 1'b0;

	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		cell_link_t link_hi;
		logic       lo_a;

		if (i == DATA_WIDTH - 1) begin : g_top
			// differences never reach the top bit, so zero shifts in
			assign link_hi = '0;
		end else begin : g_mid
			assign link_hi = links[i+1];
		end

		if (i == 0) begin : g_bottom
			assign lo_a = 1'b0;
		end else begin : g_upper
			assign lo_a = links[i-1].a;
		end

		bgcd_cell u_cell (
			.clk           (clk),
			.op            (op),
			.load_a        (mag_a[i]),
			.load_b        (mag_b[i]),
			.link_hi       (link_hi),
			.lo_a          (lo_a),
			.borrow_ab_in  (borrow_ab[i]),
			.borrow_ba_in  (borrow_ba[i]),
			.link_out      (links[i]),
			.borrow_ab_out (borrow_ab[i+1]),
			.borrow_ba_out (borrow_ba[i+1])
		);

		assign a_vec[i] = links[i].a;
		assign b_vec[i] = links[i].b;
	end

	// loop status from the row
	assign a_zero = (a_vec == '0);
	assign b_zero = (b_vec == '0);
	assign ab_equal = (a_vec == b_vec);
	assign finished = ab_equal || a_zero || b_zero;
	// no borrow out of a-b means a >= b
	assign a_greater = !borrow_ab[DATA_WIDTH];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (operand_xfer) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (finished) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (twos_q == '0 && out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer: row operation and counter control
	always_comb begin
		op = OP_HOLD;
		operand_stall = 1'b1;
		load_result = 1'b0;
		twos_inc = 1'b0;
		twos_dec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				operand_stall = 1'b0;
				if (operand_valid) begin
					op = OP_LOAD;
				end
			end
			ST_RUN: begin
				if (finished) begin
					// leave the surviving value in a
					if (a_zero) begin
						op = OP_TAKE_B;
					end
				end else if (!a_vec[0] && !b_vec[0]) begin
					op = OP_HALVE_BOTH;
					twos_inc = 1'b1;
				end else if (!a_vec[0]) begin
					op = OP_HALVE_A;
				end else if (!b_vec[0]) begin
					op = OP_HALVE_B;
				end else if (a_greater) begin
					op = OP_SUB_A;
				end else begin
					op = OP_SUB_B;
				end
			end
			ST_SCALE: begin
				if (twos_q != '0) begin
					op = OP_SHL_A;
					twos_dec = 1'b1;
				end else if (out_free) begin
					load_result = 1'b1;
				end
			end
			default: begin
				op = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			twos_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (operand_xfer) begin
				twos_q <= '0;
			end else if (twos_inc) begin
				twos_q <= twos_q + TWOS_WIDTH'(1);
			end else if (twos_dec) begin
				twos_q <= twos_q - TWOS_WIDTH'(1);
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: sign flag of the pair at work and the result register
	always_ff @(posedge clk) begin
		if (operand_xfer) begin
			neg_q <= neg_a || neg_b;
		end
		if (load_result) begin
			divisor_q <= FIELD_WIDTH'(a_vec);
			coprime_q <= (a_vec == DATA_WIDTH'(1));
			had_negative_q <= neg_q;
		end
	end

	assign result_valid = result_valid_q;
	assign divisor = divisor_q;
	assign coprime = coprime_q;
	assign had_negative = had_negative_q;

	// a taken pair always starts the loop
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		operand_xfer |=> state_q == ST_RUN)
		else $error("accepted pair did not start the loop");

	// both operands zero in the loop only when no factor of two was taken out
	a_zero_no_twos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && a_zero && b_zero) |-> twos_q == '0)
		else $error("twos counted for a zero pair");

	// finishing the scale phase fills the result register and frees the row
	a_result_written: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> result_valid_q && state_q == ST_IDLE)
		else $error("result not written on completion");

	// coprime flag agrees with the divisor
	a_coprime_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (coprime_q == (divisor_q == FIELD_WIDTH'(1))))
		else $error("coprime flag disagrees with divisor");

endmodule
